// ----- design/tag_pose_velocity_estimator_unit_macros.svh -----
// Assertion macros for the tag pose and velocity estimator.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef TAG_POSE_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`define TAG_POSE_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define TPVE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpve assertion failed");
// Checked on every clock edge, reset included.
`define TPVE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tpve reset assertion failed");
`else
`define TPVE_ASSERT(label, prop)
`define TPVE_ASSERT_RST(label, prop)
`endif
`endif

// ----- design/tpve_pkg.sv -----
// Shared types, constants and functions of the tag pose and velocity estimator.
// Used by the controller, the datapath, the divider and the top level.
package tpve_pkg;

  localparam int DIV_W     = 64;
  localparam int DEN_W     = 48;
  localparam int DIV_CNT_W = 6;
  localparam int V_W       = 36;
  localparam int NUM_PROD  = 10;

  localparam logic signed [31:0] ONE_Q30    = 32'sh4000_0000;
  localparam logic signed [31:0] S32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;
  localparam logic signed [20:0] VEL_SCALE  = 21'sd1000000;
  localparam logic [65:0]        MAC_RND    = 66'd536870912;
  localparam logic signed [31:0] OFFX_RESET = 32'sd2621;
  localparam logic signed [31:0] OFFZ_RESET = 32'sd8192;

  localparam logic CFG_OFFSET_X = 1'b0;
  localparam logic CFG_OFFSET_Z = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_MUL, OP_ROT_GO, OP_ROT_WR, OP_MAC_MUL, OP_MAC_ADD, OP_POSE,
    OP_HIST0, OP_HIST1, OP_PUPD, OP_MEAN_GO, OP_MEAN_WR, OP_VEL_GO, OP_VEL_WR,
    OP_VUPD, OP_VAVG_GO, OP_VAVG_WR, OP_SHIFT, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] ia;
    logic [1:0] ib;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'(S32_MAX)) return S32_MAX;
    else if (v < 65'(S32_MIN)) return S32_MIN;
    else return v[31:0];
  endfunction

endpackage

// ----- design/tpve_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module tpve_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 10
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- design/tpve_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tpve_pkg for its widths.
module tpve_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpve_pkg::DIV_W-1:0] num,
  input  logic [tpve_pkg::DEN_W-1:0] den,
  output logic [tpve_pkg::DIV_W-1:0] quo,
  output logic                       done
);
  import tpve_pkg::*;

  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DEN_W:0]       shifted;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule

// ----- design/tpve_dp.sv -----
// Datapath: input latch, products, rotation, windows, history and output words.
// Depends on tpve_pkg, tpve_div and tpve_ram.
module tpve_dp #(
  parameter int POS_WINDOW = 10,
  parameter int VEL_WINDOW = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tpve_pkg::dp_cmd_t       cmd,
  output tpve_pkg::dp_stat_t      stat,
  input  logic                    in_load,
  input  logic signed [31:0]      in_tag_px,
  input  logic signed [31:0]      in_tag_py,
  input  logic signed [31:0]      in_tag_pz,
  input  logic signed [15:0]      in_quat_w,
  input  logic signed [15:0]      in_quat_x,
  input  logic signed [15:0]      in_quat_y,
  input  logic signed [15:0]      in_quat_z,
  input  logic [47:0]             in_stamp_us,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_wdata,
  output logic signed [31:0]      out_avg_pos_x,
  output logic signed [31:0]      out_avg_pos_y,
  output logic signed [31:0]      out_avg_pos_z,
  output logic signed [31:0]      out_avg_vel_x,
  output logic signed [31:0]      out_avg_vel_y,
  output logic signed [31:0]      out_avg_vel_z
);
  import tpve_pkg::*;

  localparam int PAW = (POS_WINDOW > 1) ? $clog2(POS_WINDOW) : 1;
  localparam int PCW = $clog2(POS_WINDOW + 1);
  localparam int PSW = 32 + PCW;
  localparam int VAW = (VEL_WINDOW > 1) ? $clog2(VEL_WINDOW) : 1;
  localparam int VCW = $clog2(VEL_WINDOW + 1);
  localparam int VSW = 32 + VCW;
  localparam logic [PAW-1:0] PLAST = PAW'(POS_WINDOW - 1);
  localparam logic [PCW-1:0] PFULL = PCW'(POS_WINDOW);
  localparam logic [VAW-1:0] VLAST = VAW'(VEL_WINDOW - 1);
  localparam logic [VCW-1:0] VFULL = VCW'(VEL_WINDOW);

  // Product slots of the quaternion terms.
  localparam logic [3:0] P_WW = 4'd0, P_XX = 4'd1, P_YY = 4'd2, P_ZZ = 4'd3;
  localparam logic [3:0] P_XY = 4'd4, P_WZ = 4'd5, P_XZ = 4'd6, P_WY = 4'd7;
  localparam logic [3:0] P_YZ = 4'd8, P_WX = 4'd9;

  logic signed [31:0]      p_r [3];
  logic signed [15:0]      q_r [4];
  logic [47:0]             stamp_r;
  logic signed [31:0]      offx_r, offz_r;
  logic signed [31:0]      prod_r [NUM_PROD];
  logic signed [31:0]      rot_r [3][3];
  logic signed [65:0]      mprod_r;
  logic signed [V_W-1:0]   v_r [3];
  logic signed [31:0]      pose_r [3];
  logic signed [31:0]      avg_r [3];
  logic signed [31:0]      vel_r [3];
  logic signed [31:0]      vavg_r [3];
  logic signed [31:0]      older_pos_r [3];
  logic signed [31:0]      newer_pos_r [3];
  logic [47:0]             older_time_r, newer_time_r;
  logic signed [PSW-1:0]   psum_r [3];
  logic signed [VSW-1:0]   vsum_r [3];
  logic [PAW-1:0]          pptr_r;
  logic [VAW-1:0]          vptr_r;
  logic [PCW-1:0]          pfill_r;
  logic [VCW-1:0]          vfill_r;
  logic                    div_neg_r;
  logic signed [31:0]      out_r [6];

  logic [3:0]              idx;
  logic signed [15:0]      ma, mb;
  logic signed [33:0]      pe [NUM_PROD];
  logic signed [33:0]      nsum;
  logic [32:0]             n_val;
  logic                    n_zero;
  logic signed [33:0]      nument;
  logic signed [33:0]      d_v [3];
  logic signed [32:0]      vdiff;
  logic signed [53:0]      vprod;
  logic [47:0]             dt;
  logic                    dt_zero;
  logic signed [31:0]      vzsat;
  logic signed [64:0]      dnum;
  logic [64:0]             dmag;
  logic [DEN_W-1:0]        dden;
  logic                    div_start;
  logic [DIV_W-1:0]        div_num;
  logic [DIV_W-1:0]        div_quo;
  logic                    div_done;
  logic signed [64:0]      qs;
  logic [65:0]             mmag;
  logic [65:0]             mrnd;
  logic signed [V_W-1:0]   mterm;
  logic [95:0]             prdata, vrdata;
  logic                    pfull, vfull;
  logic signed [31:0]      pev [3];
  logic signed [31:0]      vev [3];

  assign idx = {cmd.ia, cmd.ib};

  always_comb begin
    case (idx)
      P_WW:    begin ma = q_r[0]; mb = q_r[0]; end
      P_XX:    begin ma = q_r[1]; mb = q_r[1]; end
      P_YY:    begin ma = q_r[2]; mb = q_r[2]; end
      P_ZZ:    begin ma = q_r[3]; mb = q_r[3]; end
      P_XY:    begin ma = q_r[1]; mb = q_r[2]; end
      P_WZ:    begin ma = q_r[0]; mb = q_r[3]; end
      P_XZ:    begin ma = q_r[1]; mb = q_r[3]; end
      P_WY:    begin ma = q_r[0]; mb = q_r[2]; end
      P_YZ:    begin ma = q_r[2]; mb = q_r[3]; end
      P_WX:    begin ma = q_r[0]; mb = q_r[1]; end
      default: begin ma = '0;     mb = '0;     end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_PROD; k++) begin
      pe[k] = 34'(prod_r[k]);
    end
  end

  assign nsum   = pe[P_WW] + pe[P_XX] + pe[P_YY] + pe[P_ZZ];
  assign n_val  = nsum[32:0];
  assign n_zero = (n_val == '0);

  // Unnormalized rotation entry for row ia, column ib.
  always_comb begin
    case (idx)
      {2'd0, 2'd0}: nument = pe[P_WW] + pe[P_XX] - pe[P_YY] - pe[P_ZZ];
      {2'd0, 2'd1}: nument = (pe[P_XY] - pe[P_WZ]) <<< 1;
      {2'd0, 2'd2}: nument = (pe[P_XZ] + pe[P_WY]) <<< 1;
      {2'd1, 2'd0}: nument = (pe[P_XY] + pe[P_WZ]) <<< 1;
      {2'd1, 2'd1}: nument = pe[P_WW] - pe[P_XX] + pe[P_YY] - pe[P_ZZ];
      {2'd1, 2'd2}: nument = (pe[P_YZ] - pe[P_WX]) <<< 1;
      {2'd2, 2'd0}: nument = (pe[P_XZ] - pe[P_WY]) <<< 1;
      {2'd2, 2'd1}: nument = (pe[P_YZ] + pe[P_WX]) <<< 1;
      {2'd2, 2'd2}: nument = pe[P_WW] - pe[P_XX] - pe[P_YY] + pe[P_ZZ];
      default:      nument = '0;
    endcase
  end

  assign d_v[0] = -34'(p_r[0]);
  assign d_v[1] = -34'(offx_r) - 34'(p_r[1]);
  assign d_v[2] = -34'(offz_r) - 34'(p_r[2]);

  assign vdiff   = 33'(avg_r[cmd.ia]) - 33'(older_pos_r[cmd.ia]);
  assign vprod   = vdiff * VEL_SCALE;
  assign dt      = stamp_r - older_time_r;
  assign dt_zero = (dt == '0);
  assign vzsat   = (vdiff > 33'sd0) ? S32_MAX : ((vdiff < 33'sd0) ? S32_MIN : 32'sd0);

  always_comb begin
    case (cmd.op)
      OP_ROT_GO:  begin dnum = 65'(nument) <<< 30;      dden = DEN_W'(n_val);   end
      OP_MEAN_GO: begin dnum = 65'(psum_r[cmd.ia]);     dden = DEN_W'(pfill_r); end
      OP_VEL_GO:  begin dnum = 65'(vprod);              dden = dt;              end
      OP_VAVG_GO: begin dnum = 65'(vsum_r[cmd.ia]);     dden = DEN_W'(vfill_r); end
      default:    begin dnum = '0;                      dden = '0;              end
    endcase
  end

  // Round to nearest with ties away from zero: divide the magnitude plus half.
  assign dmag      = dnum[64] ? 65'(-dnum) : 65'(dnum);
  assign div_num   = dmag[63:0] + DIV_W'(dden >> 1);
  assign div_start = (cmd.op == OP_ROT_GO) || (cmd.op == OP_MEAN_GO) ||
                     (cmd.op == OP_VEL_GO) || (cmd.op == OP_VAVG_GO);
  assign qs        = div_neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  assign mmag  = mprod_r[65] ? 66'(-mprod_r) : 66'(mprod_r);
  assign mrnd  = mmag + MAC_RND;
  assign mterm = mprod_r[65] ? -$signed(mrnd[65:30]) : $signed(mrnd[65:30]);

  assign pfull = (pfill_r == PFULL);
  assign vfull = (vfill_r == VFULL);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pev[a] = pfull ? $signed(prdata[a*32 +: 32]) : 32'sd0;
      vev[a] = vfull ? $signed(vrdata[a*32 +: 32]) : 32'sd0;
    end
  end

  tpve_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dden),
    .quo   (div_quo),
    .done  (div_done)
  );

  tpve_ram #(.WIDTH(96), .DEPTH(POS_WINDOW)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.op == OP_PUPD),
    .waddr (pptr_r),
    .wdata ({pose_r[2], pose_r[1], pose_r[0]}),
    .raddr (pptr_r),
    .rdata (prdata)
  );

  tpve_ram #(.WIDTH(96), .DEPTH(VEL_WINDOW)) u_vel_ram (
    .clk   (clk),
    .we    (cmd.op == OP_VUPD),
    .waddr (vptr_r),
    .wdata ({vel_r[2], vel_r[1], vel_r[0]}),
    .raddr (vptr_r),
    .rdata (vrdata)
  );

  // Registers, window sums and fill state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offx_r  <= OFFX_RESET;
      offz_r  <= OFFZ_RESET;
      pptr_r  <= '0;
      vptr_r  <= '0;
      pfill_r <= '0;
      vfill_r <= '0;
      for (int a = 0; a < 3; a++) begin
        psum_r[a] <= '0;
        vsum_r[a] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OFFSET_X: offx_r <= cfg_wdata;
          CFG_OFFSET_Z: offz_r <= cfg_wdata;
          default:      ;
        endcase
      end
      if (cmd.op == OP_PUPD) begin
        for (int a = 0; a < 3; a++) begin
          psum_r[a] <= psum_r[a] + PSW'(pose_r[a]) - PSW'(pev[a]);
        end
        pptr_r  <= (pptr_r == PLAST) ? '0 : pptr_r + 1'b1;
        pfill_r <= pfull ? PFULL : pfill_r + 1'b1;
      end
      if (cmd.op == OP_VUPD) begin
        for (int a = 0; a < 3; a++) begin
          vsum_r[a] <= vsum_r[a] + VSW'(vel_r[a]) - VSW'(vev[a]);
        end
        vptr_r  <= (vptr_r == VLAST) ? '0 : vptr_r + 1'b1;
        vfill_r <= vfull ? VFULL : vfill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      p_r[0]  <= in_tag_px;
      p_r[1]  <= in_tag_py;
      p_r[2]  <= in_tag_pz;
      q_r[0]  <= in_quat_w;
      q_r[1]  <= in_quat_x;
      q_r[2]  <= in_quat_y;
      q_r[3]  <= in_quat_z;
      stamp_r <= in_stamp_us;
      for (int a = 0; a < 3; a++) begin
        v_r[a] <= '0;
      end
    end
    if (div_start) begin
      div_neg_r <= dnum[64];
    end
    case (cmd.op)
      OP_MUL:     prod_r[idx] <= 32'(ma * mb);
      OP_ROT_WR:  rot_r[cmd.ia][cmd.ib] <= n_zero ? ((cmd.ia == cmd.ib) ? ONE_Q30 : 32'sd0)
                                                  : qs[31:0];
      OP_MAC_MUL: mprod_r <= rot_r[cmd.ib][cmd.ia] * d_v[cmd.ib];
      OP_MAC_ADD: v_r[cmd.ia] <= v_r[cmd.ia] + mterm;
      OP_POSE: begin
        pose_r[0] <= sat32(65'(v_r[1]));
        pose_r[1] <= sat32(-65'(v_r[0]));
        pose_r[2] <= sat32(65'(v_r[2]));
      end
      OP_HIST0: begin
        older_pos_r  <= pose_r;
        older_time_r <= stamp_r;
      end
      OP_HIST1: begin
        newer_pos_r  <= pose_r;
        newer_time_r <= stamp_r;
      end
      OP_MEAN_WR: avg_r[cmd.ia]  <= qs[31:0];
      OP_VEL_WR:  vel_r[cmd.ia]  <= dt_zero ? vzsat : sat32(qs);
      OP_VAVG_WR: vavg_r[cmd.ia] <= qs[31:0];
      OP_SHIFT: begin
        older_pos_r  <= newer_pos_r;
        older_time_r <= newer_time_r;
        newer_pos_r  <= avg_r;
        newer_time_r <= stamp_r;
      end
      OP_OUT: begin
        for (int a = 0; a < 3; a++) begin
          out_r[a]     <= avg_r[a];
          out_r[3 + a] <= vavg_r[a];
        end
      end
      default: ;
    endcase
  end

  assign stat.div_done = div_done;
  assign out_avg_pos_x = out_r[0];
  assign out_avg_pos_y = out_r[1];
  assign out_avg_pos_z = out_r[2];
  assign out_avg_vel_x = out_r[3];
  assign out_avg_vel_y = out_r[4];
  assign out_avg_vel_z = out_r[5];
endmodule

// ----- design/tpve_ctrl.sv -----
// Controller: sequences the datapath for one word and runs both handshakes.
// Depends on tpve_pkg for the command and status types.
module tpve_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tpve_pkg::dp_cmd_t  cmd,
  input  tpve_pkg::dp_stat_t stat
);
  import tpve_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ROT_GO, S_ROT_WAIT, S_MAC_MUL, S_MAC_ADD, S_POSE, S_HIST,
    S_DIV_GO, S_DIV_WAIT, S_VUPD, S_SHIFT, S_OUT, S_OUT_VALID
  } state_t;

  typedef enum logic [1:0] {G_MEAN, G_VEL, G_VAVG} grp_t;

  localparam logic [3:0] MUL_LAST = 4'(NUM_PROD - 1);
  localparam logic [1:0] IDX_LAST = 2'd2;
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_RUN = 2'd2;

  state_t     state_r;
  grp_t       grp_r;
  dp_cmd_t    cmd_r;
  dp_cmd_t    cmd_nxt;
  logic       in_ready_r, out_valid_r;
  logic [1:0] phase_r;
  logic [3:0] cnt_r;
  logic [1:0] ia_r, ib_r;
  logic       ij_last;

  assign ij_last = (ia_r == IDX_LAST) && (ib_r == IDX_LAST);

  // Command issued to the datapath in the next cycle.
  always_comb begin
    cmd_nxt = '{op: OP_NONE, ia: ia_r, ib: ib_r};
    case (state_r)
      S_MUL:      cmd_nxt = '{op: OP_MUL, ia: cnt_r[3:2], ib: cnt_r[1:0]};
      S_ROT_GO:   cmd_nxt.op = OP_ROT_GO;
      S_ROT_WAIT: begin
        if (stat.div_done) begin
          cmd_nxt.op = OP_ROT_WR;
        end
      end
      S_MAC_MUL:  cmd_nxt.op = OP_MAC_MUL;
      S_MAC_ADD:  cmd_nxt.op = OP_MAC_ADD;
      S_POSE:     cmd_nxt.op = OP_POSE;
      S_HIST: begin
        case (phase_r)
          PH_FIRST:  cmd_nxt.op = OP_HIST0;
          PH_SECOND: cmd_nxt.op = OP_HIST1;
          default:   cmd_nxt.op = OP_PUPD;
        endcase
      end
      S_DIV_GO: begin
        case (grp_r)
          G_MEAN:  cmd_nxt.op = OP_MEAN_GO;
          G_VEL:   cmd_nxt.op = OP_VEL_GO;
          default: cmd_nxt.op = OP_VAVG_GO;
        endcase
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          case (grp_r)
            G_MEAN:  cmd_nxt.op = OP_MEAN_WR;
            G_VEL:   cmd_nxt.op = OP_VEL_WR;
            default: cmd_nxt.op = OP_VAVG_WR;
          endcase
        end
      end
      S_VUPD:     cmd_nxt.op = OP_VUPD;
      S_SHIFT:    cmd_nxt.op = OP_SHIFT;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd_nxt.op = OP_OUT;
        end
      end
      default:    cmd_nxt.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grp_r       <= G_MEAN;
      cmd_r       <= '{op: OP_NONE, ia: 2'd0, ib: 2'd0};
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FIRST;
      cnt_r       <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
    end else begin
      cmd_r <= cmd_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            cnt_r      <= '0;
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt_r == MUL_LAST) begin
            ia_r    <= '0;
            ib_r    <= '0;
            state_r <= S_ROT_GO;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ROT_GO: begin
          state_r <= S_ROT_WAIT;
        end
        S_ROT_WAIT: begin
          if (stat.div_done) begin
            if (ij_last) begin
              ia_r    <= '0;
              ib_r    <= '0;
              state_r <= S_MAC_MUL;
            end else begin
              state_r <= S_ROT_GO;
              if (ib_r == IDX_LAST) begin
                ib_r <= '0;
                ia_r <= ia_r + 1'b1;
              end else begin
                ib_r <= ib_r + 1'b1;
              end
            end
          end
        end
        S_MAC_MUL: begin
          state_r <= S_MAC_ADD;
        end
        S_MAC_ADD: begin
          if (ij_last) begin
            state_r <= S_POSE;
          end else begin
            state_r <= S_MAC_MUL;
            if (ib_r == IDX_LAST) begin
              ib_r <= '0;
              ia_r <= ia_r + 1'b1;
            end else begin
              ib_r <= ib_r + 1'b1;
            end
          end
        end
        S_POSE: begin
          state_r <= S_HIST;
        end
        S_HIST: begin
          ia_r <= '0;
          case (phase_r)
            PH_FIRST: begin
              phase_r    <= PH_SECOND;
              in_ready_r <= 1'b1;
              state_r    <= S_IDLE;
            end
            PH_SECOND: begin
              phase_r    <= PH_RUN;
              in_ready_r <= 1'b1;
              state_r    <= S_IDLE;
            end
            default: begin
              grp_r   <= G_MEAN;
              state_r <= S_DIV_GO;
            end
          endcase
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            if (ia_r == IDX_LAST) begin
              ia_r <= '0;
              case (grp_r)
                G_MEAN: begin
                  grp_r   <= G_VEL;
                  state_r <= S_DIV_GO;
                end
                G_VEL:   state_r <= S_VUPD;
                default: state_r <= S_SHIFT;
              endcase
            end else begin
              ia_r    <= ia_r + 1'b1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_VUPD: begin
          grp_r   <= G_VAVG;
          state_r <= S_DIV_GO;
        end
        S_SHIFT: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_OUT_VALID;
          end
        end
        S_OUT_VALID: begin
          out_valid_r <= 1'b1;
          in_ready_r  <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd       = cmd_r;
  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
endmodule

// ----- design/tag_pose_velocity_estimator_unit.sv -----
// Top level of the tag pose and velocity estimator.
// Depends on tpve_pkg, tpve_ctrl, tpve_dp and the assertion macro header.
//
//   Channel  | Handshake              | Contents
//   ---------+------------------------+-------------------------------------------
//   in_      | in_valid / in_ready    | tag position, quaternion, stamp (one word)
//   out_     | out_valid / out_ready  | averaged position and velocity (one word)
//   cfg_     | cfg_we, no wait        | offset_x (index 0), offset_z (index 1)
//
// While the two history slots fill, a word ends once its pose is in a slot;
// afterwards each word also runs the averages and velocities before the input
// side reopens. The time is set by the shared bit-serial divider: every quotient
// takes a start, one step per quotient bit, the done pulse and the write, nine
// for the rotation and nine more for the averages and velocities, plus ten
// multiplies, a multiply and accumulate step per rotation entry and the
// bookkeeping states. One word is worked on at a time. A finished word waits in
// the output register while the next input word is taken; a receiver that
// holds off longer than one word's processing stalls the output step and with
// it the input. Reset is synchronous and active low and needs no clearing pass.
`include "tag_pose_velocity_estimator_unit_macros.svh"

module tag_pose_velocity_estimator_unit #(
  parameter int POS_WINDOW = 10,
  parameter int VEL_WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_tag_px,
  input  logic signed [31:0] in_tag_py,
  input  logic signed [31:0] in_tag_pz,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic [47:0]        in_stamp_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_avg_pos_x,
  output logic signed [31:0] out_avg_pos_y,
  output logic signed [31:0] out_avg_pos_z,
  output logic signed [31:0] out_avg_vel_x,
  output logic signed [31:0] out_avg_vel_y,
  output logic signed [31:0] out_avg_vel_z,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import tpve_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_load;

  // The input word is captured in the datapath at the accepting edge itself.
  assign in_load = in_valid && in_ready;

  tpve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tpve_dp #(
    .POS_WINDOW (POS_WINDOW),
    .VEL_WINDOW (VEL_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_load       (in_load),
    .in_tag_px     (in_tag_px),
    .in_tag_py     (in_tag_py),
    .in_tag_pz     (in_tag_pz),
    .in_quat_w     (in_quat_w),
    .in_quat_x     (in_quat_x),
    .in_quat_y     (in_quat_y),
    .in_quat_z     (in_quat_z),
    .in_stamp_us   (in_stamp_us),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_avg_pos_x (out_avg_pos_x),
    .out_avg_pos_y (out_avg_pos_y),
    .out_avg_pos_z (out_avg_pos_z),
    .out_avg_vel_x (out_avg_vel_x),
    .out_avg_vel_y (out_avg_vel_y),
    .out_avg_vel_z (out_avg_vel_z)
  );

  // Once a word is taken, no second word is taken until it is processed.
  `TPVE_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
  // A result is posted in the same cycle the input side reopens.
  `TPVE_ASSERT(a_post_with_ready, $rose(out_valid) |-> in_ready)
  // Reset leaves the block empty and ready for a word.
  `TPVE_ASSERT_RST(a_reset_state, !rst_n |=> (!out_valid && in_ready))
endmodule

// ----- verif/tag_pose_velocity_estimator_unit_tb.sv -----
// Self-checking testbench of the tag pose and velocity estimator.
// Depends on tpve_pkg and the tag_pose_velocity_estimator_unit top level.
module tag_pose_velocity_estimator_unit_tb;
  import tpve_pkg::*;

  // One detection word as it enters the block.
  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qw, qx, qy, qz;
    logic [47:0]        stamp;
  } detection_t;

  // One averaged pose and velocity word as it leaves the block.
  typedef struct {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
  } estimate_t;

  // The estimator model and the list of estimates still owed by the block.
  class estimate_board;
    longint offset_x = 2621;
    longint offset_z = 8192;
    int              phase = 0;
    longint          older_pos[3], newer_pos[3];
    longint unsigned older_time, newer_time;
    longint          pos_win[10][3], vel_win[10][3];
    int              pos_cnt = 0, vel_cnt = 0;
    estimate_t       owed[int];
    int              owed_head = 0, owed_tail = 0;
    int              errors = 0;

    function int owed_count();
      return owed_tail - owed_head;
    endfunction

    function void set_offset(logic idx, logic signed [31:0] val);
      if (idx == CFG_OFFSET_X) offset_x = longint'(val);
      else offset_z = longint'(val);
    endfunction

    // Division of a signed value by a positive one, rounded half away from zero.
    function longint round_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Rotates the offset-corrected tag position back into the camera pose.
    function void pose_of(detection_t d, output longint pose[3]);
      longint w, x, y, z, n;
      longint num[3][3], r[3][3], dv[3], v[3];
      w = longint'(d.qw); x = longint'(d.qx); y = longint'(d.qy); z = longint'(d.qz);
      n = w*w + x*x + y*y + z*z;
      num[0][0] = w*w + x*x - y*y - z*z;
      num[0][1] = 2*(x*y - w*z);
      num[0][2] = 2*(x*z + w*y);
      num[1][0] = 2*(x*y + w*z);
      num[1][1] = w*w - x*x + y*y - z*z;
      num[1][2] = 2*(y*z - w*x);
      num[2][0] = 2*(x*z - w*y);
      num[2][1] = 2*(y*z + w*x);
      num[2][2] = w*w - x*x - y*y + z*z;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          r[i][j] = (n == 0) ? ((i == j) ? 64'sd1073741824 : 0)
                             : round_div(num[i][j] * 64'sd1073741824, n);
      dv[0] = -longint'(d.px);
      dv[1] = -offset_x - longint'(d.py);
      dv[2] = -offset_z - longint'(d.pz);
      for (int i = 0; i < 3; i++) begin
        v[i] = 0;
        for (int j = 0; j < 3; j++)
          v[i] += round_div(r[j][i] * dv[j], 64'sd1073741824);
      end
      pose[0] = clamp32(v[1]);
      pose[1] = clamp32(-v[0]);
      pose[2] = clamp32(v[2]);
    endfunction

    // Called for every accepted detection; records any estimate it causes.
    function void note_detection(detection_t d);
      longint pose[3], avg[3], vel[3], vavg[3], sum, diff;
      longint unsigned st, dt;
      estimate_t e;
      pose_of(d, pose);
      st = 64'(d.stamp);
      if (phase == 0) begin
        older_pos = pose; older_time = st; phase = 1;
        return;
      end
      if (phase == 1) begin
        newer_pos = pose; newer_time = st; phase = 2;
        return;
      end
      if (pos_cnt >= 10) begin
        for (int i = 1; i < 10; i++) pos_win[i-1] = pos_win[i];
        pos_cnt = 9;
      end
      pos_win[pos_cnt] = pose;
      pos_cnt++;
      for (int a = 0; a < 3; a++) begin
        sum = 0;
        for (int i = 0; i < pos_cnt; i++) sum += pos_win[i][a];
        avg[a] = round_div(sum, longint'(pos_cnt));
      end
      dt = (st - older_time) & 64'hFFFF_FFFF_FFFF;
      for (int a = 0; a < 3; a++) begin
        diff = avg[a] - older_pos[a];
        if (dt == 0)
          vel[a] = (diff > 0) ? 64'sd2147483647 : ((diff < 0) ? -64'sd2147483648 : 0);
        else
          vel[a] = clamp32(round_div(diff * 1000000, longint'(dt)));
      end
      if (vel_cnt >= 10) begin
        for (int i = 1; i < 10; i++) vel_win[i-1] = vel_win[i];
        vel_cnt = 9;
      end
      vel_win[vel_cnt] = vel;
      vel_cnt++;
      for (int a = 0; a < 3; a++) begin
        sum = 0;
        for (int i = 0; i < vel_cnt; i++) sum += vel_win[i][a];
        vavg[a] = round_div(sum, longint'(vel_cnt));
      end
      older_pos = newer_pos; older_time = newer_time;
      newer_pos = avg; newer_time = st;
      e.pos_x = 32'(avg[0]); e.pos_y = 32'(avg[1]); e.pos_z = 32'(avg[2]);
      e.vel_x = 32'(vavg[0]); e.vel_y = 32'(vavg[1]); e.vel_z = 32'(vavg[2]);
      owed[owed_tail] = e;
      owed_tail++;
    endfunction

    // Called for every accepted result word.
    function void check_estimate(estimate_t got);
      estimate_t e;
      if (owed_count() == 0) begin
        $error("result word with no estimate pending");
        errors++;
        return;
      end
      e = owed[owed_head];
      owed.delete(owed_head);
      owed_head++;
      if (got.pos_x !== e.pos_x) begin
        $error("avg_pos_x expected %0d got %0d", e.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("avg_pos_y expected %0d got %0d", e.pos_y, got.pos_y); errors++;
      end
      if (got.pos_z !== e.pos_z) begin
        $error("avg_pos_z expected %0d got %0d", e.pos_z, got.pos_z); errors++;
      end
      if (got.vel_x !== e.vel_x) begin
        $error("avg_vel_x expected %0d got %0d", e.vel_x, got.vel_x); errors++;
      end
      if (got.vel_y !== e.vel_y) begin
        $error("avg_vel_y expected %0d got %0d", e.vel_y, got.vel_y); errors++;
      end
      if (got.vel_z !== e.vel_z) begin
        $error("avg_vel_z expected %0d got %0d", e.vel_z, got.vel_z); errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_tag_px = '0, in_tag_py = '0, in_tag_pz = '0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic [47:0]        in_stamp_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_avg_pos_x, out_avg_pos_y, out_avg_pos_z;
  logic signed [31:0] out_avg_vel_x, out_avg_vel_y, out_avg_vel_z;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [31:0]        cfg_wdata = '0;

  tag_pose_velocity_estimator_unit DUT (.*);

  estimate_board board = new();

  // Idle percentages of the sender and the receiver for the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // The main flow bumps this to ask the receiver for one long hold-off.
  int unsigned holdoff_req = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;
  logic [47:0] last_stamp = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random back-pressure, plus the long hold-off when asked.
  // Every accepted result word goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        board.check_estimate('{out_avg_pos_x, out_avg_pos_y, out_avg_pos_z,
                               out_avg_vel_x, out_avg_vel_y, out_avg_vel_z});
      if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        out_ready <= 1'b0;
      end else if (holdoff_seen != holdoff_req) begin
        holdoff_seen <= holdoff_req;
        holdoff_left <= 4000;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Register writes happen only while the block is idle.
  task automatic write_offset(logic idx, logic signed [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_offset(idx, val);
  endtask

  // Offers one detection word, with random idle cycles ahead of it, and
  // holds it until the block takes it.
  task automatic send_detection(detection_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tag_px <= d.px; in_tag_py <= d.py; in_tag_pz <= d.pz;
    in_quat_w <= d.qw; in_quat_x <= d.qx; in_quat_y <= d.qy; in_quat_z <= d.qz;
    in_stamp_us <= d.stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_detection(d);
    last_stamp = d.stamp;
  endtask

  task automatic send_fields(int px, int py, int pz, int qw, int qx,
                             int qy, int qz, logic [47:0] st);
    detection_t d;
    d = '{px, py, pz, 16'(qw), 16'(qx), 16'(qy), 16'(qz), st};
    send_detection(d);
  endtask

  function automatic logic signed [31:0] rand_coord();
    // Mostly a few metres either way, sometimes anything at all.
    if ($urandom_range(7) == 0) return $urandom;
    return $signed($urandom_range(2 * 655360)) - 655360;
  endfunction

  function automatic logic signed [15:0] rand_quat_part(int mode);
    case (mode)
      0: return 16'sd0;
      1: return 16'($urandom);
      default: return 16'($signed($urandom_range(2 * 16000)) - 16000);
    endcase
  endfunction

  // Mostly a steady camera frame rate; now and then a repeated, a
  // backwards or a wild stamp.
  function automatic logic [47:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return last_stamp + $urandom_range(50000, 10000);
    if (pick < 85) return last_stamp;
    if (pick < 90) return 48'({$urandom, $urandom});
    if (pick < 95) return last_stamp - $urandom_range(100000, 1);
    return last_stamp + 1;
  endfunction

  task automatic send_random(int count);
    detection_t d;
    int qmode;
    for (int k = 0; k < count; k++) begin
      qmode = ($urandom_range(15) == 0) ? 0 : (($urandom_range(3) == 0) ? 1 : 2);
      d.px = rand_coord(); d.py = rand_coord(); d.pz = rand_coord();
      d.qw = rand_quat_part(qmode); d.qx = rand_quat_part(qmode);
      d.qy = rand_quat_part(qmode); d.qz = rand_quat_part(qmode);
      d.stamp = next_stamp();
      send_detection(d);
    end
    in_valid <= 1'b0;
  endtask

  // The sender waits until the block owes nothing, then lets the block settle.
  task automatic drain();
    @(posedge clk);
    while (board.owed_count() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_offset(CFG_OFFSET_X, 32'sd2621);
    write_offset(CFG_OFFSET_Z, 32'sd8192);

    // Directed words: two warm-up words, identity and zero quaternions,
    // extreme components, extreme positions, a repeated stamp
    // and stamps that wrap and run backwards.
    send_idle_pct = 7;
    recv_idle_pct = 72;
    send_fields(0, 0, 0, 32767, 0, 0, 0, 48'd0);
    send_fields(65536, -65536, 131072, 32767, 0, 0, 0, 48'd33333);
    send_fields(70000, -60000, 140000, 0, 0, 0, 0, 48'd66666);
    send_fields(70000, -60000, 140000, 0, 0, 0, 0, 48'd66666);
    send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                -32768, -32768, -32768, -32768, 48'd100000);
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32767, 32767, 32767, 32767, 48'd133333);
    send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                -32768, 32767, -32768, 32767, 48'd133333);
    send_fields(-1, 1, -1, 0, -32768, 0, 0, 48'hFFFF_FFFF_FFFF);
    send_fields(123456, -654321, 99999, 0, 0, -32768, 0, 48'd5);
    send_fields(-123456, 654321, -99999, 0, 0, 0, -32768, 48'd2);
    send_fields(0, 0, 0, 23170, 23170, 0, 0, 48'd40000);
    send_fields(200000, 300000, -400000, 16384, -16384, 16384, -16384, 48'd80000);
    send_fields(1, 1, 1, 1, 0, 0, 0, 48'd80001);
    send_fields(1, 1, 1, 0, 1, 1, 0, 48'hFFFF_FFFF_FFFF);
    in_valid <= 1'b0;
    last_stamp = 48'd1000;
    send_random(180);
    drain();

    // Extreme offsets, with the sender idling most of the time.
    write_offset(CFG_OFFSET_X, 32'sh7FFF_FFFF);
    write_offset(CFG_OFFSET_Z, 32'sh8000_0000);
    send_idle_pct = 72;
    recv_idle_pct = 7;
    send_random(185);
    drain();

    // Random offsets, no idling, and one long receiver hold-off so that the
    // block fills up and stalls its input while words keep coming.
    write_offset(CFG_OFFSET_X, $urandom);
    write_offset(CFG_OFFSET_Z, $urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_req = holdoff_req + 1;
    send_random(185);
    drain();

    write_offset(CFG_OFFSET_X, 32'sh8000_0000);
    write_offset(CFG_OFFSET_Z, 32'sh7FFF_FFFF);
    send_random(185);
    drain();

    if (board.errors == 0 && board.owed_count() == 0) begin
      $display("tag_pose_velocity_estimator_unit regression: pass");
    end else begin
      $display("tag_pose_velocity_estimator_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: about 750 words, with heavy back-pressure on top, stays well
  // inside this bound.
  initial begin
    #20000000;
    $display("tag_pose_velocity_estimator_unit regression: fail");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/tpve_pkg.sv
design/tpve_ram.sv
design/tpve_div.sv
design/tpve_dp.sv
design/tpve_ctrl.sv
design/tag_pose_velocity_estimator_unit.sv
verif/tag_pose_velocity_estimator_unit_tb.sv
